FILE: hdl/sdnf_pkg.sv
// ----------------------------------------------------------------------------
// sdnf_pkg
// Widths, sideband types and register codes shared by the spring-damper
// force pipeline.
// ----------------------------------------------------------------------------
package sdnf_pkg;

   localparam int InW     = 32;
   localparam int CoefW   = 31;
   localparam int CsrIdxW = 2;
   localparam int DiffW   = InW + 1;
   localparam int MagW    = InW + 1;
   localparam int SumW    = 2 * MagW;
   localparam int DotW    = SumW + 1;
   localparam int LenW    = MagW;
   localparam int SqRemW  = LenW + 2;
   localparam int RateQW  = 35;
   localparam int StrW    = LenW + 2;
   localparam int SmagW   = LenW;
   localparam int SmagLoW = 17;
   localparam int RmagLoW = 18;
   localparam int KsW     = CoefW + SmagW;
   localparam int CrW     = CoefW + RateQW;
   localparam int FW      = CrW + 2;
   localparam int FmagW   = FW - 1;
   localparam int FmagLoW = 34;
   localparam int ProdW   = FmagW + MagW;
   localparam int FracW   = 16;
   localparam int DivNW   = ProdW - FracW;
   localparam int QuoW    = InW;

   localparam logic [CsrIdxW-1:0] CSR_STIFFNESS   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_DAMPING     = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_REST_LENGTH = 2'd2;

   localparam logic [CoefW-1:0] STIFFNESS_RESET   = 31'd65536;
   localparam logic [CoefW-1:0] DAMPING_RESET     = 31'd3277;
   localparam logic [CoefW-1:0] REST_LENGTH_RESET = 31'd65536;

   typedef logic [2:0][InW-1:0]  vec3_type;
   typedef logic [2:0][MagW-1:0] mag3_type;

   typedef struct packed {
      mag3_type   dmag;
      logic [2:0] dneg;
      logic       zero;
   } geom_type;

   typedef struct packed {
      logic signed [DotW-1:0] dot;
      geom_type               geom;
   } sqrt_tag_type;

   typedef struct packed {
      logic [LenW-1:0] len;
      logic            dot_neg;
      geom_type        geom;
   } rate_tag_type;

   typedef struct packed {
      logic pos;
      logic zero;
   } comp_tag_type;

endpackage

FILE: hdl/sdnf_front.sv
// ----------------------------------------------------------------------------
// sdnf_front
// Separation and relative velocity, squares and dot terms, and their sums.
// Three register stages.
// ----------------------------------------------------------------------------
module sdnf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  sdnf_pkg::vec3_type         obj_pos,
   input  sdnf_pkg::vec3_type         obj_vel,
   input  sdnf_pkg::vec3_type         anchor_pos,
   input  sdnf_pkg::vec3_type         anchor_vel,
   output logic                       out_valid,
   output logic [sdnf_pkg::SumW-1:0]  out_sum,
   output sdnf_pkg::sqrt_tag_type     out_tag
);
   import sdnf_pkg::*;

   logic                   v1_ff, v2_ff, v3_ff;
   logic signed [DiffW-1:0] d_in [3];
   logic signed [DiffW-1:0] r_in [3];
   logic signed [DiffW-1:0] d_ff [3];
   logic signed [DiffW-1:0] r_ff [3];
   logic [MagW-1:0]        m_in [3];
   logic [SumW-1:0]        sq_ff [3];
   logic signed [SumW-1:0] pr_ff [3];
   logic signed [DotW-1:0] pe [3];
   mag3_type               m2_ff, m3_ff;
   logic [2:0]             n2_ff, n3_ff;
   logic [SumW-1:0]        sum_ff;
   logic signed [DotW-1:0] dot_ff;
   logic                   zero_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = {obj_pos[i][InW-1], obj_pos[i]} - {anchor_pos[i][InW-1], anchor_pos[i]};
         r_in[i] = {obj_vel[i][InW-1], obj_vel[i]} - {anchor_vel[i][InW-1], anchor_vel[i]};
         m_in[i] = d_ff[i][DiffW-1] ? MagW'(-d_ff[i]) : MagW'(d_ff[i]);
         pe[i]   = DotW'(pr_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         d_ff[i]  <= d_in[i];
         r_ff[i]  <= r_in[i];
         sq_ff[i] <= m_in[i] * m_in[i];
         pr_ff[i] <= d_ff[i] * r_ff[i];
         m2_ff[i] <= m_in[i];
         n2_ff[i] <= d_ff[i][DiffW-1];
      end
      sum_ff  <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      dot_ff  <= pe[0] + pe[1] + pe[2];
      m3_ff   <= m2_ff;
      n3_ff   <= n2_ff;
      zero_ff <= (m2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_sum   = sum_ff;
   assign out_tag   = '{dot: dot_ff, geom: '{dmag: m3_ff, dneg: n3_ff, zero: zero_ff}};

endmodule

FILE: hdl/sdnf_sqrt.sv
// ----------------------------------------------------------------------------
// sdnf_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module sdnf_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [sdnf_pkg::SumW-1:0]  in_sum,
   input  sdnf_pkg::sqrt_tag_type     in_tag,
   output logic                       out_valid,
   output logic [sdnf_pkg::LenW-1:0]  out_len,
   output sdnf_pkg::sqrt_tag_type     out_tag
);
   import sdnf_pkg::*;

   localparam int Steps = LenW;

   logic                vld_ff  [Steps];
   logic [SqRemW-1:0]   rem_ff  [Steps];
   logic [SqRemW-1:0]   rem_in  [Steps];
   logic [LenW-1:0]     root_ff [Steps];
   logic [LenW-1:0]     root_in [Steps];
   logic [SumW-1:0]     rad_ff  [Steps];
   logic [SumW-1:0]     rad_in  [Steps];
   sqrt_tag_type        tag_ff  [Steps];

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic              pv;
      logic [SqRemW-1:0] prem;
      logic [LenW-1:0]   proot;
      logic [SumW-1:0]   prad;
      sqrt_tag_type      ptag;
      logic [SqRemW+1:0] cat, trial;
      logic              ge;

      if (s == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = '0;
         assign proot = '0;
         assign prad  = in_sum;
         assign ptag  = in_tag;
      end else begin : g_next
         assign pv    = vld_ff[s-1];
         assign prem  = rem_ff[s-1];
         assign proot = root_ff[s-1];
         assign prad  = rad_ff[s-1];
         assign ptag  = tag_ff[s-1];
      end

      always_comb begin
         cat        = {prem, prad[SumW-1 -: 2]};
         trial      = {2'b00, proot, 2'b01};
         ge         = (cat >= trial);
         rem_in[s]  = ge ? SqRemW'(cat - trial) : SqRemW'(cat);
         root_in[s] = {proot[LenW-2:0], ge};
         rad_in[s]  = {prad[SumW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
         rad_ff[s]  <= rad_in[s];
         tag_ff[s]  <= ptag;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= pv;
         end
      end
   end

   assign out_valid = vld_ff[Steps-1];
   assign out_len   = root_ff[Steps-1];
   assign out_tag   = tag_ff[Steps-1];

endmodule

FILE: hdl/sdnf_rate_div.sv
// ----------------------------------------------------------------------------
// sdnf_rate_div
// Length rate: |dot| / length, pipelined restoring divide, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module sdnf_rate_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [sdnf_pkg::LenW-1:0]    in_len,
   input  sdnf_pkg::sqrt_tag_type       in_tag,
   output logic                         out_valid,
   output logic [sdnf_pkg::RateQW-1:0]  out_quo,
   output sdnf_pkg::rate_tag_type       out_tag
);
   import sdnf_pkg::*;

   localparam int Steps = RateQW;

   logic [SumW-1:0]   num;
   rate_tag_type      tag0;
   logic              vld_ff [Steps];
   logic [LenW-1:0]   rem_ff [Steps];
   logic [LenW-1:0]   rem_in [Steps];
   logic [RateQW-1:0] quo_ff [Steps];
   logic [RateQW-1:0] quo_in [Steps];
   logic [RateQW-1:0] low_ff [Steps];
   logic [RateQW-1:0] low_in [Steps];
   rate_tag_type      tag_ff [Steps];

   always_comb begin
      num  = in_tag.dot[DotW-1] ? SumW'(-in_tag.dot) : SumW'(in_tag.dot);
      tag0 = '{len: in_len, dot_neg: in_tag.dot[DotW-1], geom: in_tag.geom};
   end

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic              pv;
      logic [LenW-1:0]   prem;
      logic [RateQW-1:0] pquo;
      logic [RateQW-1:0] plow;
      rate_tag_type      ptag;
      logic [LenW:0]     cat, dvs;
      logic              ge;

      if (s == 0) begin : g_first
         assign pv   = in_valid;
         assign prem = LenW'(num[SumW-1:RateQW]);
         assign pquo = '0;
         assign plow = num[RateQW-1:0];
         assign ptag = tag0;
      end else begin : g_next
         assign pv   = vld_ff[s-1];
         assign prem = rem_ff[s-1];
         assign pquo = quo_ff[s-1];
         assign plow = low_ff[s-1];
         assign ptag = tag_ff[s-1];
      end

      always_comb begin
         cat       = {prem, plow[RateQW-1]};
         dvs       = {1'b0, ptag.len};
         ge        = (cat >= dvs);
         rem_in[s] = ge ? LenW'(cat - dvs) : LenW'(cat);
         quo_in[s] = {pquo[RateQW-2:0], ge};
         low_in[s] = {plow[RateQW-2:0], 1'b0};
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         low_ff[s] <= low_in[s];
         tag_ff[s] <= ptag;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= pv;
         end
      end
   end

   assign out_valid = vld_ff[Steps-1];
   assign out_quo   = quo_ff[Steps-1];
   assign out_tag   = tag_ff[Steps-1];

endmodule

FILE: hdl/sdnf_comp_div.sv
// ----------------------------------------------------------------------------
// sdnf_comp_div
// One force component: (|F| * |d| >> 16) / length, with an overflow flag
// for quotients past 32 bits. Range check stage, then one bit per stage.
// ----------------------------------------------------------------------------
module sdnf_comp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [sdnf_pkg::DivNW-1:0]  in_num,
   input  logic [sdnf_pkg::LenW-1:0]   in_len,
   input  sdnf_pkg::comp_tag_type      in_tag,
   output logic                        out_valid,
   output logic [sdnf_pkg::QuoW-1:0]   out_quo,
   output logic                        out_ovf,
   output sdnf_pkg::comp_tag_type      out_tag
);
   import sdnf_pkg::*;

   localparam int Steps = QuoW;
   localparam int HiW   = DivNW - QuoW;

   logic            v0_ff;
   logic            ovf0_ff;
   logic [LenW-1:0] rem0_ff;
   logic [QuoW-1:0] low0_ff;
   logic [LenW-1:0] len0_ff;
   comp_tag_type    tag0_ff;

   logic            vld_ff [Steps];
   logic            ovf_ff [Steps];
   logic [LenW-1:0] rem_ff [Steps];
   logic [LenW-1:0] rem_in [Steps];
   logic [QuoW-1:0] quo_ff [Steps];
   logic [QuoW-1:0] quo_in [Steps];
   logic [QuoW-1:0] low_ff [Steps];
   logic [QuoW-1:0] low_in [Steps];
   logic [LenW-1:0] len_ff [Steps];
   comp_tag_type    tag_ff [Steps];

   always_ff @(posedge clock) begin
      ovf0_ff <= (in_num[DivNW-1:QuoW] >= HiW'(in_len));
      rem0_ff <= in_num[QuoW +: LenW];
      low0_ff <= in_num[QuoW-1:0];
      len0_ff <= in_len;
      tag0_ff <= in_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
   end

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic            pv, povf;
      logic [LenW-1:0] prem, plen;
      logic [QuoW-1:0] pquo, plow;
      comp_tag_type    ptag;
      logic [LenW:0]   cat, dvs;
      logic            ge;

      if (s == 0) begin : g_first
         assign pv   = v0_ff;
         assign povf = ovf0_ff;
         assign prem = rem0_ff;
         assign pquo = '0;
         assign plow = low0_ff;
         assign plen = len0_ff;
         assign ptag = tag0_ff;
      end else begin : g_next
         assign pv   = vld_ff[s-1];
         assign povf = ovf_ff[s-1];
         assign prem = rem_ff[s-1];
         assign pquo = quo_ff[s-1];
         assign plow = low_ff[s-1];
         assign plen = len_ff[s-1];
         assign ptag = tag_ff[s-1];
      end

      always_comb begin
         cat       = {prem, plow[QuoW-1]};
         dvs       = {1'b0, plen};
         ge        = (cat >= dvs);
         rem_in[s] = ge ? LenW'(cat - dvs) : LenW'(cat);
         quo_in[s] = {pquo[QuoW-2:0], ge};
         low_in[s] = {plow[QuoW-2:0], 1'b0};
      end

      always_ff @(posedge clock) begin
         ovf_ff[s] <= povf;
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         low_ff[s] <= low_in[s];
         len_ff[s] <= plen;
         tag_ff[s] <= ptag;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= pv;
         end
      end
   end

   assign out_valid = vld_ff[Steps-1];
   assign out_quo   = quo_ff[Steps-1];
   assign out_ovf   = ovf_ff[Steps-1];
   assign out_tag   = tag_ff[Steps-1];

endmodule

FILE: hdl/spring_damper_node_force.sv
// ----------------------------------------------------------------------------
// spring_damper_node_force
// Linear spring-damper force on one node in 3D, signed Q16.16, as a deep
// pipeline: front end, square root, length-rate divide, force multiply,
// per-component divide with saturation.
//
//   channel   handshake              data
//   request   start / busy           req_node_*, req_anchor_* (12 x 32)
//   response  rsp_strobe             rsp_force_x/y/z, rsp_zero_length
//   config    csr_valid / csr_ready  csr_index, csr_data
//
// One word enters per cycle while busy is low; the register stages run front
// end, root, rate divide, force, component divide, then output.
// busy and csr_ready follow reset only. Reset clears the stage valid bits
// and loads the coefficient defaults. The response has no stall; each word
// is on the rsp_ ports for one cycle under rsp_strobe.
// ----------------------------------------------------------------------------
module spring_damper_node_force (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [sdnf_pkg::InW-1:0]      req_node_pos_x,
   input  logic [sdnf_pkg::InW-1:0]      req_node_pos_y,
   input  logic [sdnf_pkg::InW-1:0]      req_node_pos_z,
   input  logic [sdnf_pkg::InW-1:0]      req_node_vel_x,
   input  logic [sdnf_pkg::InW-1:0]      req_node_vel_y,
   input  logic [sdnf_pkg::InW-1:0]      req_node_vel_z,
   input  logic [sdnf_pkg::InW-1:0]      req_anchor_pos_x,
   input  logic [sdnf_pkg::InW-1:0]      req_anchor_pos_y,
   input  logic [sdnf_pkg::InW-1:0]      req_anchor_pos_z,
   input  logic [sdnf_pkg::InW-1:0]      req_anchor_vel_x,
   input  logic [sdnf_pkg::InW-1:0]      req_anchor_vel_y,
   input  logic [sdnf_pkg::InW-1:0]      req_anchor_vel_z,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sdnf_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [sdnf_pkg::CoefW-1:0]    csr_data,
   output logic                          rsp_strobe,
   output logic [sdnf_pkg::InW-1:0]      rsp_force_x,
   output logic [sdnf_pkg::InW-1:0]      rsp_force_y,
   output logic [sdnf_pkg::InW-1:0]      rsp_force_z,
   output logic                          rsp_zero_length
);
   import sdnf_pkg::*;

   localparam logic [QuoW-1:0] PosMax = {1'b0, {(QuoW-1){1'b1}}};
   localparam logic [QuoW-1:0] NegMax = {1'b1, {(QuoW-1){1'b0}}};

   function automatic logic [InW-1:0] sat_force(input logic [QuoW-1:0] q,
                                                input logic ovf, input logic pos,
                                                input logic zero);
      logic [InW-1:0] r;
      if (zero) begin
         r = '0;
      end else if (pos) begin
         r = (ovf || q > PosMax) ? PosMax : q;
      end else begin
         r = (ovf || q > NegMax) ? NegMax : (~q + 1'b1);
      end
      return r;
   endfunction

   logic [CoefW-1:0] stiff_ff, damp_ff, rest_ff;

   vec3_type         obj_pos, obj_vel, anchor_pos, anchor_vel;
   logic             fr_valid;
   logic [SumW-1:0]  fr_sum;
   sqrt_tag_type     fr_tag;
   logic             sq_valid;
   logic [LenW-1:0]  sq_len;
   sqrt_tag_type     sq_tag;
   logic             rd_valid;
   logic [RateQW-1:0] rd_quo;
   rate_tag_type     rd_tag;

   // force stages
   logic                   f0_ff, f1_ff, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff;
   logic signed [StrW-1:0] stretch;
   logic [SmagW-1:0]       smag_ff;
   logic                   sneg0_ff, sneg1_ff, sneg2_ff;
   logic [RateQW-1:0]      rmag_ff;
   logic                   rneg0_ff, rneg1_ff, rneg2_ff;
   geom_type               g0_ff, g1_ff, g2_ff, g3_ff, g4_ff;
   logic [LenW-1:0]        l0_ff, l1_ff, l2_ff, l3_ff, l4_ff, l5_ff, l6_ff;
   logic [CoefW+SmagLoW-1:0]        p0_ff;
   logic [CoefW+SmagW-SmagLoW-1:0]  p1_ff;
   logic [CoefW+RmagLoW-1:0]        p2_ff;
   logic [CoefW+RateQW-RmagLoW-1:0] p3_ff;
   logic [KsW-1:0]         ks_ff;
   logic [CrW-1:0]         cr_ff;
   logic signed [FW-1:0]   ks_s, cr_s, f_ff;
   logic [FmagW-1:0]       fmag_ff;
   logic [2:0]             pos4_ff, pos5_ff, pos6_ff;
   logic                   z5_ff, z6_ff;
   logic [FmagLoW+MagW-1:0]       pl_ff [3];
   logic [FmagW-FmagLoW+MagW-1:0] ph_ff [3];
   logic [ProdW-1:0]       prod_in [3];
   logic [DivNW-1:0]       num_ff [3];

   logic [2:0]             cd_valid;
   logic [QuoW-1:0]        cd_quo [3];
   logic [2:0]             cd_ovf;
   comp_tag_type           cd_tag [3];

   logic                   strobe_ff;
   logic [InW-1:0]         fx_ff, fy_ff, fz_ff;
   logic                   zl_ff;

   assign busy      = reset;
   assign csr_ready = ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= STIFFNESS_RESET;
         damp_ff  <= DAMPING_RESET;
         rest_ff  <= REST_LENGTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STIFFNESS:   stiff_ff <= csr_data;
            CSR_DAMPING:     damp_ff  <= csr_data;
            CSR_REST_LENGTH: rest_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign obj_pos    = {req_node_pos_z, req_node_pos_y, req_node_pos_x};
   assign obj_vel    = {req_node_vel_z, req_node_vel_y, req_node_vel_x};
   assign anchor_pos = {req_anchor_pos_z, req_anchor_pos_y, req_anchor_pos_x};
   assign anchor_vel = {req_anchor_vel_z, req_anchor_vel_y, req_anchor_vel_x};

   sdnf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start & ~busy),
      .obj_pos    (obj_pos),
      .obj_vel    (obj_vel),
      .anchor_pos (anchor_pos),
      .anchor_vel (anchor_vel),
      .out_valid  (fr_valid),
      .out_sum    (fr_sum),
      .out_tag    (fr_tag)
   );

   sdnf_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_sum    (fr_sum),
      .in_tag    (fr_tag),
      .out_valid (sq_valid),
      .out_len   (sq_len),
      .out_tag   (sq_tag)
   );

   sdnf_rate_div u_rate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_len    (sq_len),
      .in_tag    (sq_tag),
      .out_valid (rd_valid),
      .out_quo   (rd_quo),
      .out_tag   (rd_tag)
   );

   always_comb begin
      stretch = $signed({2'b00, rd_tag.len}) - $signed({{(StrW-CoefW){1'b0}}, rest_ff});
      ks_s    = sneg2_ff ? -$signed(FW'(ks_ff)) : $signed(FW'(ks_ff));
      cr_s    = rneg2_ff ? -$signed(FW'(cr_ff)) : $signed(FW'(cr_ff));
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = ProdW'(pl_ff[i]) + (ProdW'(ph_ff[i]) << FmagLoW);
      end
   end

   always_ff @(posedge clock) begin
      // stretch and magnitudes
      smag_ff  <= stretch[StrW-1] ? SmagW'(-stretch) : SmagW'(stretch);
      sneg0_ff <= stretch[StrW-1];
      rmag_ff  <= rd_quo;
      rneg0_ff <= rd_tag.dot_neg;
      g0_ff    <= rd_tag.geom;
      l0_ff    <= rd_tag.len;
      // partial products
      p0_ff    <= stiff_ff * smag_ff[SmagLoW-1:0];
      p1_ff    <= stiff_ff * smag_ff[SmagW-1:SmagLoW];
      p2_ff    <= damp_ff * rmag_ff[RmagLoW-1:0];
      p3_ff    <= damp_ff * rmag_ff[RateQW-1:RmagLoW];
      sneg1_ff <= sneg0_ff;
      rneg1_ff <= rneg0_ff;
      g1_ff    <= g0_ff;
      l1_ff    <= l0_ff;
      // term magnitudes
      ks_ff    <= KsW'(p0_ff) + (KsW'(p1_ff) << SmagLoW);
      cr_ff    <= CrW'(p2_ff) + (CrW'(p3_ff) << RmagLoW);
      sneg2_ff <= sneg1_ff;
      rneg2_ff <= rneg1_ff;
      g2_ff    <= g1_ff;
      l2_ff    <= l1_ff;
      // scalar force
      f_ff     <= ks_s + cr_s;
      g3_ff    <= g2_ff;
      l3_ff    <= l2_ff;
      // magnitude and component signs
      fmag_ff  <= f_ff[FW-1] ? FmagW'(-f_ff) : FmagW'(f_ff);
      pos4_ff  <= {3{f_ff[FW-1]}} ^ g3_ff.dneg;
      g4_ff    <= g3_ff;
      l4_ff    <= l3_ff;
      // component products
      for (int i = 0; i < 3; i++) begin
         pl_ff[i] <= fmag_ff[FmagLoW-1:0] * g4_ff.dmag[i];
         ph_ff[i] <= fmag_ff[FmagW-1:FmagLoW] * g4_ff.dmag[i];
         num_ff[i] <= prod_in[i][ProdW-1:FracW];
      end
      pos5_ff  <= pos4_ff;
      z5_ff    <= g4_ff.zero;
      l5_ff    <= l4_ff;
      pos6_ff  <= pos5_ff;
      z6_ff    <= z5_ff;
      l6_ff    <= l5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_ff <= 1'b0;
         f1_ff <= 1'b0;
         f2_ff <= 1'b0;
         f3_ff <= 1'b0;
         f4_ff <= 1'b0;
         f5_ff <= 1'b0;
         f6_ff <= 1'b0;
      end else begin
         f0_ff <= rd_valid;
         f1_ff <= f0_ff;
         f2_ff <= f1_ff;
         f3_ff <= f2_ff;
         f4_ff <= f3_ff;
         f5_ff <= f4_ff;
         f6_ff <= f5_ff;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_comp
      sdnf_comp_div u_comp (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (f6_ff),
         .in_num    (num_ff[i]),
         .in_len    (l6_ff),
         .in_tag    ('{pos: pos6_ff[i], zero: z6_ff}),
         .out_valid (cd_valid[i]),
         .out_quo   (cd_quo[i]),
         .out_ovf   (cd_ovf[i]),
         .out_tag   (cd_tag[i])
      );
   end

   always_ff @(posedge clock) begin
      fx_ff <= sat_force(cd_quo[0], cd_ovf[0], cd_tag[0].pos, cd_tag[0].zero);
      fy_ff <= sat_force(cd_quo[1], cd_ovf[1], cd_tag[1].pos, cd_tag[1].zero);
      fz_ff <= sat_force(cd_quo[2], cd_ovf[2], cd_tag[2].pos, cd_tag[2].zero);
      zl_ff <= cd_tag[0].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= &cd_valid;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_force_x     = fx_ff;
   assign rsp_force_y     = fy_ff;
   assign rsp_force_z     = fz_ff;
   assign rsp_zero_length = zl_ff;

endmodule

FILE: dv/tb_spring_damper_node_force.sv
// ----------------------------------------------------------------------------
// tb_spring_damper_node_force
// Self-checking bench for the spring-damper node force pipeline. A short
// table of directed nodes runs first, then random nodes under several
// coefficient settings. Every accepted node gets an expected force, either
// typed in its table row or from an in-bench fixed-point force predictor,
// and each response word is compared with the oldest expected force.
// ----------------------------------------------------------------------------
module tb_spring_damper_node_force;
   timeunit 1ns;
   timeprecision 1ps;
   import sdnf_pkg::*;

   localparam logic [CsrIdxW-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 130;
   localparam int RAND_PER_PHASE = 200;

   typedef struct {
      logic [InW-1:0] npos [3];
      logic [InW-1:0] nvel [3];
      logic [InW-1:0] apos [3];
      logic [InW-1:0] avel [3];
   } node_word_type;

   typedef struct {
      logic [InW-1:0] f [3];
      logic           zl;
   } force_word_type;

   typedef struct {
      node_word_type  w;
      logic           typed;
      force_word_type want;
   } dir_row_type;

   logic clock, reset, start, busy;
   logic [InW-1:0] npos [3], nvel [3], apos [3], avel [3];
   logic csr_valid, csr_ready;
   logic [CsrIdxW-1:0] csr_index;
   logic [CoefW-1:0] csr_data;
   logic rsp_strobe, rsp_zero_length;
   logic [InW-1:0] rsp_force_x, rsp_force_y, rsp_force_z;

   logic [CoefW-1:0] k_coef, c_coef, rest_len;
   force_word_type force_q [$];
   int errors;
   int sent;

   spring_damper_node_force DUT (
      .clock, .reset, .start, .busy,
      .req_node_pos_x(npos[0]), .req_node_pos_y(npos[1]), .req_node_pos_z(npos[2]),
      .req_node_vel_x(nvel[0]), .req_node_vel_y(nvel[1]), .req_node_vel_z(nvel[2]),
      .req_anchor_pos_x(apos[0]), .req_anchor_pos_y(apos[1]),
      .req_anchor_pos_z(apos[2]),
      .req_anchor_vel_x(avel[0]), .req_anchor_vel_y(avel[1]),
      .req_anchor_vel_z(avel[2]),
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .rsp_strobe, .rsp_force_x, .rsp_force_y, .rsp_force_z, .rsp_zero_length
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("** spring_damper_node_force: FAILED **");
      $finish;
   end

   function automatic force_word_type node_force(input node_word_type w);
      force_word_type r;
      longint d [3], v [3];
      logic [127:0] sum, len, t, num, den, q, m;
      logic signed [127:0] dot, sd, sv, slen, rate, f, fmag;
      logic fneg, pos;
      sum = '0;
      dot = '0;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'($signed(w.npos[i])) - longint'($signed(w.apos[i]));
         v[i] = longint'($signed(w.nvel[i])) - longint'($signed(w.avel[i]));
         m = 128'((d[i] < 0) ? -d[i] : d[i]);
         sum += m * m;
         sd = 128'(d[i]);
         sv = 128'(v[i]);
         dot += sd * sv;
      end
      len = '0;
      for (int b = 33; b >= 0; b--) begin
         t = len | (128'd1 << b);
         if (t * t <= sum) len = t;
      end
      r.zl = (len == 0);
      r.f[0] = '0; r.f[1] = '0; r.f[2] = '0;
      if (len == 0) return r;
      slen = len;
      rate = dot / slen;
      f = $signed({97'd0, k_coef}) * (slen - $signed({97'd0, rest_len}))
        + $signed({97'd0, c_coef}) * rate;
      fneg = f < 0;
      fmag = fneg ? -f : f;
      den = len << 16;
      for (int i = 0; i < 3; i++) begin
         m = 128'((d[i] < 0) ? -d[i] : d[i]);
         num = fmag * m;
         q = num / den;
         pos = fneg != (d[i] < 0);
         if (q == 0) r.f[i] = '0;
         else if (pos) r.f[i] = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
         else r.f[i] = (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      force_word_type e;
      if (!reset && rsp_strobe) begin
         if (force_q.size() == 0) begin
            $error("force word with nothing pending");
            errors++;
         end else begin
            e = force_q.pop_front();
            if (rsp_force_x !== e.f[0]) begin
               $error("force_x: expected %h, got %h", e.f[0], rsp_force_x);
               errors++;
            end
            if (rsp_force_y !== e.f[1]) begin
               $error("force_y: expected %h, got %h", e.f[1], rsp_force_y);
               errors++;
            end
            if (rsp_force_z !== e.f[2]) begin
               $error("force_z: expected %h, got %h", e.f[2], rsp_force_z);
               errors++;
            end
            if (rsp_zero_length !== e.zl) begin
               $error("zero_length: expected %b, got %b", e.zl, rsp_zero_length);
               errors++;
            end
         end
      end
   end

   task automatic send_node(input node_word_type w, input logic typed,
                            input force_word_type want);
      int pct;
      pct = (sent < 400) ? 33 : (sent < 800) ? 46 : 0;
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      npos <= w.npos; nvel <= w.nvel; apos <= w.apos; avel <= w.avel;
      do @(posedge clock); while (busy);
      force_q.insert(force_q.size(), typed ? want : node_force(w));
      sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (force_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_coef(input logic [CsrIdxW-1:0] idx, input logic [CoefW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_STIFFNESS:   k_coef   = val;
         CSR_DAMPING:     c_coef   = val;
         CSR_REST_LENGTH: rest_len = val;
         default: ;
      endcase
   endtask

   function automatic node_word_type rand_node();
      node_word_type w;
      int mode;
      mode = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         w.apos[i] = $urandom;
         w.avel[i] = $urandom;
         case (mode)
            0, 1, 2, 3: begin
               w.npos[i] = $urandom;
               w.nvel[i] = $urandom;
            end
            8: begin
               w.npos[i] = w.apos[i];
               w.nvel[i] = $urandom;
            end
            9: begin
               w.npos[i] = w.apos[i] + $signed($urandom_range(8)) - 4;
               w.nvel[i] = w.avel[i] + $signed($urandom_range(64)) - 32;
            end
            default: begin
               w.npos[i] = w.apos[i] + $signed($urandom_range(1 << 21)) - (1 << 20);
               w.nvel[i] = w.avel[i] + $signed($urandom_range(1 << 19)) - (1 << 18);
            end
         endcase
      end
      return w;
   endfunction

   initial begin
      dir_row_type rows [$];
      dir_row_type row;
      force_word_type none;
      logic [CoefW-1:0] ks [6], cs [6], rs [6];
      none.f[0] = '0; none.f[1] = '0; none.f[2] = '0; none.zl = 1'b1;

      errors = 0;
      sent = 0;
      k_coef = STIFFNESS_RESET;
      c_coef = DAMPING_RESET;
      rest_len = REST_LENGTH_RESET;
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_STIFFNESS;
      csr_data = '0;
      for (int i = 0; i < 3; i++) begin
         npos[i] = '0; nvel[i] = '0; apos[i] = '0; avel[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: coincident points, extremes, unit and tiny offsets
      for (int n = 0; n < 12; n++) begin
         row.typed = 1'b0;
         row.want = none;
         for (int i = 0; i < 3; i++) begin
            row.w.npos[i] = '0; row.w.nvel[i] = '0;
            row.w.apos[i] = '0; row.w.avel[i] = '0;
         end
         for (int i = 0; i < 3; i++) begin
            case (n)
               0: row.typed = 1'b1;
               1: begin
                  row.typed = 1'b1;
                  row.w.npos[i] = 32'h7FFF_FFFF; row.w.apos[i] = 32'h7FFF_FFFF;
                  row.w.nvel[i] = 32'h7FFF_FFFF; row.w.avel[i] = 32'h8000_0000;
               end
               2: begin
                  row.typed = 1'b1;
                  row.w.npos[i] = 32'h8000_0000; row.w.apos[i] = 32'h8000_0000;
                  row.w.nvel[i] = 32'h8000_0000; row.w.avel[i] = 32'h7FFF_FFFF;
               end
               3: begin
                  row.w.npos[i] = 32'h7FFF_FFFF; row.w.apos[i] = 32'h8000_0000;
               end
               4: begin
                  row.w.npos[i] = 32'h8000_0000; row.w.apos[i] = 32'h7FFF_FFFF;
                  row.w.nvel[i] = 32'h7FFF_FFFF; row.w.avel[i] = 32'h8000_0000;
               end
               5: begin
                  row.w.npos[i] = 32'h8000_0000; row.w.apos[i] = 32'h7FFF_FFFF;
                  row.w.nvel[i] = 32'h8000_0000; row.w.avel[i] = 32'h7FFF_FFFF;
               end
               6: if (i == 0) row.w.npos[i] = 32'h0001_0000;
               7: if (i == 1) row.w.npos[i] = 32'h0002_0000;
               8: if (i == 2) row.w.apos[i] = 32'h0000_0001;
               9: begin
                  row.w.npos[i] = 32'hFFFF_0000;
                  row.w.nvel[i] = 32'h0000_8000;
               end
               10: begin
                  row.w.npos[i] = 32'hFFFF_FFFF; row.w.apos[i] = 32'hFFFF_FFFF;
                  row.w.avel[i] = 32'h1234_5678;
                  if (i == 0) row.w.npos[i] = 32'h0;
               end
               default: begin
                  row.w.npos[i] = 32'h5555_5555; row.w.apos[i] = 32'hAAAA_AAAA;
                  row.w.nvel[i] = 32'hAAAA_AAAA; row.w.avel[i] = 32'h5555_5555;
               end
            endcase
         end
         rows.insert(rows.size(), row);
      end
      foreach (rows[n]) send_node(rows[n].w, rows[n].typed, rows[n].want);
      drain();

      ks[0] = 31'h7FFF_FFFF; cs[0] = 31'h7FFF_FFFF; rs[0] = 31'h7FFF_FFFF;
      ks[1] = '0;            cs[1] = '0;            rs[1] = '0;
      ks[2] = '0;            cs[2] = 31'h7FFF_FFFF; rs[2] = '0;
      ks[3] = 31'h7FFF_FFFF; cs[3] = '0;            rs[3] = 31'h0001_0000;
      for (int p = 4; p < 6; p++) begin
         ks[p] = CoefW'($urandom_range(1 << 20));
         cs[p] = CoefW'($urandom_range(1 << 18));
         rs[p] = CoefW'($urandom);
      end

      // random nodes, one block per coefficient setting
      for (int p = 0; p < 6; p++) begin
         write_coef(CSR_STIFFNESS, ks[p]);
         write_coef(CSR_DAMPING, cs[p]);
         write_coef(CSR_REST_LENGTH, rs[p]);
         if (p == 2) write_coef(CSR_UNUSED, 31'h7FFF_FFFF);
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            if (p == 3 && n == 100) begin
               start <= 1'b0;
               while (force_q.size() != 0) @(posedge clock);
            end
            send_node(rand_node(), 1'b0, none);
         end
         drain();
      end

      if (errors == 0) begin
         $display("** spring_damper_node_force: PASSED **");
      end else begin
         $display("** spring_damper_node_force: FAILED **");
      end
      $finish;
   end

endmodule
